// ===== rtl/kuf_pkg.sv =====
`default_nettype none

package kuf_pkg;

  // Fixed field widths of the edge transaction and the node count register.
  localparam int NODE_W      = 10;
  localparam int NCOUNT_W    = 11;
  localparam int EDGE_OUT_W  = 10;

  localparam int MAX_NODES_DEF = 1024;
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  // Function codes carried by the input transaction.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_EDGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FIND,
    ST_COMP,
    ST_DONE
  } kuf_state_t;

endpackage

`default_nettype wire

// ===== rtl/kruskal_union_find_edge_select.sv =====
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------------
// in_      | input     | in_valid / in_stall  | func, from_node, to_node, last_edge
// out_     | output    | out_valid / out_stall| accepted, tree_complete, edges_in_tree,
//          |           |                      | ran_out
// cfg_     | input     | cfg_valid / cfg_ready| node_count
//
// For an edge that reaches the root search, the single read port of the parent memory serves
// one step a cycle, for each endpoint in turn: first to find its root by walking its parent
// chain, then to compress that path. An edge out of range or after completion skips the search;
// a start rewrites every parent entry first. After reset the same clearing pass runs, in_stall high.
// A stalled result waits in the output register while the next transaction is worked on.

module kruskal_union_find_edge_select
  import kuf_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input transaction channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_func,
  input  wire logic [NODE_W-1:0]     in_from_node,
  input  wire logic [NODE_W-1:0]     in_to_node,
  input  wire logic                  in_last_edge,
  // Result transaction channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_accepted,
  output logic                       out_tree_complete,
  output logic [EDGE_OUT_W-1:0]      out_edges_in_tree,
  output logic                       out_ran_out,
  // Node count register write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [NCOUNT_W-1:0]   cfg_node_count
);

  // Node index width inside the block, set by the size of the parent memory.
  localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  // Largest node count in use after clamping: the memory size, capped at what the 11-bit register can express.
  localparam int NCAP = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
  localparam logic [NCOUNT_W-1:0] NCAP_W  = NCOUNT_W'(NCAP);
  localparam logic [AW-1:0]       LAST_IX = AW'(MAX_NODES - 1);

  // Parent memory: one write and one registered read per cycle.
  logic [AW-1:0] parent_mem [MAX_NODES];
  logic [AW-1:0] rd_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem[waddr] <= wdata;
    end
    rd_r <= parent_mem[raddr];
  end

  // Control state.
  kuf_state_t          state_r, state_nxt;
  logic [NCOUNT_W-1:0] node_count_r;
  logic [AW-1:0]       edges_r, edges_nxt;
  logic                done_r, done_nxt;
  logic [AW-1:0]       clr_ix_r, clr_ix_nxt;
  logic                clr_item_r, clr_item_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Working registers of the root search unit.
  logic [AW-1:0] node_r, node_nxt;   // endpoint whose root is being found
  logic [AW-1:0] root_r, root_nxt;   // walking pointer, the root once found
  logic [AW-1:0] cur_r, cur_nxt;     // compression pointer
  logic [AW-1:0] ra_r, ra_nxt;       // root of from_node
  logic [AW-1:0] b_r, b_nxt;         // to_node, kept for the second search
  logic          sel_b_r, sel_b_nxt; // second endpoint in progress
  logic          acc_r, acc_nxt;
  logic          last_r, last_nxt;

  // Output payload registers.
  logic                  out_acc_r, out_acc_nxt;
  logic                  out_cmp_r, out_cmp_nxt;
  logic [EDGE_OUT_W-1:0] out_edges_r, out_edges_nxt;
  logic                  out_ro_r, out_ro_nxt;

  logic                in_accept;
  logic [NCOUNT_W-1:0] n_eff;
  logic [31:0]         n_ext;
  logic [31:0]         edges_ext;
  logic [31:0]         edges_inc_ext;
  logic                done_now;
  logic                in_range;
  logic                out_load;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // The node count register is clamped to the range the forest supports.
  always_comb begin
    if (node_count_r < NCOUNT_W'(2)) begin
      n_eff = NCOUNT_W'(2);
    end else if (node_count_r > NCAP_W) begin
      n_eff = NCAP_W;
    end else begin
      n_eff = node_count_r;
    end
  end

  assign n_ext         = 32'(n_eff);
  assign edges_ext     = 32'(edges_r);
  assign edges_inc_ext = edges_ext + 32'd1;
  assign done_now      = done_r || (edges_ext >= n_ext - 32'd1);
  assign in_range      = ({1'b0, in_from_node} < n_eff) && ({1'b0, in_to_node} < n_eff);

  always_comb begin
    state_nxt     = state_r;
    edges_nxt     = edges_r;
    done_nxt      = done_r;
    clr_ix_nxt    = clr_ix_r;
    clr_item_nxt  = clr_item_r;
    node_nxt      = node_r;
    root_nxt      = root_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    b_nxt         = b_r;
    sel_b_nxt     = sel_b_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    raddr         = root_r;
    we            = 1'b0;
    waddr         = clr_ix_r;
    wdata         = clr_ix_r;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          acc_nxt = 1'b0;
          if (in_func == FUNC_START) begin
            // A new forest: zero the counters and rewrite every parent entry.
            edges_nxt    = '0;
            done_nxt     = 1'b0;
            last_nxt     = 1'b0;
            clr_ix_nxt   = '0;
            clr_item_nxt = 1'b1;
            state_nxt    = ST_CLEAR;
          end else begin
            done_nxt = done_now;
            last_nxt = in_last_edge;
            if (!done_now && in_range) begin
              // Start the root walk at from_node; its parent arrives next cycle.
              node_nxt  = AW'(in_from_node);
              root_nxt  = AW'(in_from_node);
              b_nxt     = AW'(in_to_node);
              sel_b_nxt = 1'b0;
              raddr     = AW'(in_from_node);
              state_nxt = ST_FIND;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_CLEAR: begin
        we         = 1'b1;
        waddr      = clr_ix_r;
        wdata      = clr_ix_r;
        clr_ix_nxt = clr_ix_r + AW'(1);
        if (clr_ix_r == LAST_IX) begin
          state_nxt = clr_item_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_FIND: begin
        // rd_r holds the parent of root_r; a node that is its own parent is the root.
        if (rd_r == root_r) begin
          cur_nxt   = node_r;
          raddr     = node_r;
          state_nxt = ST_COMP;
        end else begin
          root_nxt = rd_r;
          raddr    = rd_r;
        end
      end

      ST_COMP: begin
        // rd_r holds the parent of cur_r; point cur_r straight at the root and move on.
        if (cur_r == root_r) begin
          if (!sel_b_r) begin
            ra_nxt    = root_r;
            sel_b_nxt = 1'b1;
            node_nxt  = b_r;
            root_nxt  = b_r;
            raddr     = b_r;
            state_nxt = ST_FIND;
          end else begin
            if (ra_r != root_r) begin
              // Different trees: hang the second root under the first.
              we        = 1'b1;
              waddr     = root_r;
              wdata     = ra_r;
              edges_nxt = edges_r + AW'(1);
              acc_nxt   = 1'b1;
              if (edges_inc_ext >= n_ext - 32'd1) begin
                done_nxt = 1'b1;
              end
            end
            state_nxt = ST_DONE;
          end
        end else begin
          we      = 1'b1;
          waddr   = cur_r;
          wdata   = root_r;
          cur_nxt = rd_r;
          raddr   = rd_r;
        end
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_load     = 1'b1;
          clr_item_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  logic [31:0] edges_pub;
  assign edges_pub     = 32'(edges_r);
  assign out_acc_nxt   = out_load ? acc_r : out_acc_r;
  assign out_cmp_nxt   = out_load ? done_r : out_cmp_r;
  assign out_edges_nxt = out_load ? edges_pub[EDGE_OUT_W-1:0] : out_edges_r;
  assign out_ro_nxt    = out_load ? (last_r && !done_r) : out_ro_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      node_count_r <= NODE_COUNT_RST;
      edges_r      <= '0;
      done_r       <= 1'b0;
      clr_ix_r     <= '0;
      clr_item_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edges_r      <= edges_nxt;
      done_r       <= done_nxt;
      clr_ix_r     <= clr_ix_nxt;
      clr_item_r   <= clr_item_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  // Working and payload registers carry no reset.
  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    root_r      <= root_nxt;
    cur_r       <= cur_nxt;
    ra_r        <= ra_nxt;
    b_r         <= b_nxt;
    sel_b_r     <= sel_b_nxt;
    acc_r       <= acc_nxt;
    last_r      <= last_nxt;
    out_acc_r   <= out_acc_nxt;
    out_cmp_r   <= out_cmp_nxt;
    out_edges_r <= out_edges_nxt;
    out_ro_r    <= out_ro_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_tree_complete = out_cmp_r;
  assign out_edges_in_tree = out_edges_r;
  assign out_ran_out       = out_ro_r;

endmodule

`default_nettype wire

// ===== rtl/kuf_checker.sv =====
`default_nettype none

module kuf_checker
  import kuf_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_accepted,
  input wire logic                  out_tree_complete,
  input wire logic [EDGE_OUT_W-1:0] out_edges_in_tree,
  input wire logic                  out_ran_out
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accepted)
      && $stable(out_tree_complete) && $stable(out_edges_in_tree) && $stable(out_ran_out))
    else $error("stalled result changed");

  // A complete tree never reports that the edge list ran out.
  a_done_not_ranout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tree_complete && out_ran_out))
    else $error("tree_complete and ran_out both set");

  // Taking a transaction always makes the block stall its input before it can take another.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in two consecutive cycles");

  // The parent memory is being rewritten right after reset.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("input not stalled during clearing pass");

endmodule

bind kruskal_union_find_edge_select kuf_checker u_kuf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_accepted      (out_accepted),
  .out_tree_complete (out_tree_complete),
  .out_edges_in_tree (out_edges_in_tree),
  .out_ran_out       (out_ran_out)
);

`default_nettype wire

// ===== tb/sv/tb_kruskal_union_find_edge_select.sv =====
`default_nettype none

module tb_kruskal_union_find_edge_select;
  import kuf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One input transaction as the sender presents it.
  typedef struct packed {
    logic                  func;
    logic [NODE_W-1:0]     from_node;
    logic [NODE_W-1:0]     to_node;
    logic                  last_edge;
  } edge_item_t;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic                  accepted;
    logic                  tree_complete;
    logic [EDGE_OUT_W-1:0] edges_in_tree;
    logic                  ran_out;
  } verdict_t;

  // The scoreboard keeps its own copy of the union-find forest and of the
  // node count register. Every accepted input transaction is played against
  // that copy, and the verdict it produces waits in a queue until the block
  // delivers the matching result.
  class forest_scoreboard;
    logic [NODE_W-1:0]   up_link [MAX_NODES_DEF];
    int                  taken;
    bit                  done;
    logic [NCOUNT_W-1:0] node_count_reg;
    verdict_t            verdict_q[$];
    int                  errors;

    function new();
      node_count_reg = NODE_COUNT_RST;
      errors = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      foreach (up_link[i]) up_link[i] = i[NODE_W-1:0];
      taken = 0;
      done = 1'b0;
    endfunction

    function void set_node_count(logic [NCOUNT_W-1:0] value);
      node_count_reg = value;
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction

    // Counts below two behave as two, counts past the memory size as the
    // memory size.
    function int nodes_in_use();
      int n;
      n = int'(node_count_reg);
      if (n < 2) n = 2;
      if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
      return n;
    endfunction

    // Walk up to the root, then point every node on the path straight at it.
    function int find_root(int v);
      int r;
      int cur;
      int nxt;
      int steps;
      r = v;
      steps = 0;
      while (int'(up_link[r]) != r && steps < MAX_NODES_DEF) begin
        r = int'(up_link[r]);
        steps++;
      end
      cur = v;
      steps = 0;
      while (cur != r && steps < MAX_NODES_DEF) begin
        nxt = int'(up_link[cur]);
        up_link[cur] = r[NODE_W-1:0];
        cur = nxt;
        steps++;
      end
      return r;
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function void take_item(edge_item_t it);
      verdict_t v;
      int n;
      int ra;
      int rb;
      v = '0;
      if (it.func == FUNC_START) begin
        clear_forest();
        verdict_q.push_back(v);
        return;
      end
      n = nodes_in_use();
      // Completion is tested before the edge too, so that a lowered node
      // count closes a forest that already holds enough edges.
      if (taken >= n - 1) done = 1'b1;
      if (!done && int'(it.from_node) < n && int'(it.to_node) < n) begin
        ra = find_root(int'(it.from_node));
        rb = find_root(int'(it.to_node));
        if (ra != rb) begin
          up_link[rb] = ra[NODE_W-1:0];
          taken++;
          v.accepted = 1'b1;
          if (taken >= n - 1) done = 1'b1;
        end
      end
      v.tree_complete = done;
      v.edges_in_tree = taken[EDGE_OUT_W-1:0];
      v.ran_out = it.last_edge && !done;
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        note_failure($sformatf("result with none outstanding: acc=%0b cmp=%0b edges=%0d ro=%0b",
                               got.accepted, got.tree_complete, got.edges_in_tree,
                               got.ran_out));
        return;
      end
      want = verdict_q.pop_front();
      if (got.accepted !== want.accepted || got.tree_complete !== want.tree_complete ||
          got.edges_in_tree !== want.edges_in_tree || got.ran_out !== want.ran_out) begin
        note_failure($sformatf({"expected acc=%0b cmp=%0b edges=%0d ro=%0b, ",
                                "got acc=%0b cmp=%0b edges=%0d ro=%0b"},
                               want.accepted, want.tree_complete, want.edges_in_tree,
                               want.ran_out, got.accepted, got.tree_complete,
                               got.edges_in_tree, got.ran_out));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_func;
  logic [NODE_W-1:0]     in_from_node;
  logic [NODE_W-1:0]     in_to_node;
  logic                  in_last_edge;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_accepted;
  logic                  out_tree_complete;
  logic [EDGE_OUT_W-1:0] out_edges_in_tree;
  logic                  out_ran_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [NCOUNT_W-1:0]   cfg_node_count;

  forest_scoreboard sb = new();

  // Transactions of the phase that is about to be sent.
  edge_item_t pending[$];
  // When set, the sender offers the phase back to back without gaps.
  bit         no_idle;
  // Asks the receiver for one long hold-off; it reports back when taken.
  bit         choke_req;
  bit         choke_done;

  kruskal_union_find_edge_select u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_from_node      (in_from_node),
    .in_to_node        (in_to_node),
    .in_last_edge      (in_last_edge),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_tree_complete (out_tree_complete),
    .out_edges_in_tree (out_edges_in_tree),
    .out_ran_out       (out_ran_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_node_count    (cfg_node_count)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results are sampled at the rising edge. Outputs and out_stall hold
  // their pre-edge values here, since the testbench only drives on the
  // falling edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_verdict('{out_accepted, out_tree_complete, out_edges_in_tree, out_ran_out});
    end
  end

  // Receiver. Most of the time it alternates between runs with no stall and
  // short stalls; now and then it stalls for a longer stretch. Once, on
  // request, it holds off for longer than a clearing pass so that the block's
  // result register fills up and its input stalls while the sender keeps
  // offering transactions. The request is picked up at the next falling edge.
  initial begin
    int  len;
    int  r;
    bit  v;
    out_stall = 1'b0;
    forever begin
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        v = 1'b1;
        len = 1600;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          v = 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 94) begin
          v = 1'b1;
          len = $urandom_range(1, 4);
        end else begin
          v = 1'b1;
          len = $urandom_range(20, 80);
        end
      end
      repeat (len) begin
        @(negedge clk);
        if (choke_req && !choke_done) break;
        out_stall <= v;
      end
    end
  end

  // Sender gap: mostly none, often short, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_start();
    edge_item_t it;
    // The endpoint and last-edge fields of a start are don't-care, so
    // they carry random values.
    it.func = FUNC_START;
    it.from_node = NODE_W'($urandom);
    it.to_node = NODE_W'($urandom);
    it.last_edge = 1'($urandom);
    pending.push_back(it);
  endtask

  task automatic push_edge(int a, int b, bit last);
    edge_item_t it;
    it.func = FUNC_EDGE;
    it.from_node = a[NODE_W-1:0];
    it.to_node = b[NODE_W-1:0];
    it.last_edge = last;
    pending.push_back(it);
  endtask

  // Sends every pending transaction. Valid is only lowered for a gap, and
  // raised again no earlier than the following falling edge; after the last
  // transaction it drops so that no stale payload is taken twice.
  task automatic feed_pending();
    edge_item_t it;
    int gap;
    while (pending.size() > 0) begin
      it = pending.pop_front();
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_func <= it.func;
      in_from_node <= it.from_node;
      in_to_node <= it.to_node;
      in_last_edge <= it.last_edge;
      do @(posedge clk); while (in_stall);
      sb.take_item(it);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // The register is only written while the block is idle: every result has
  // come back and a few more cycles have passed.
  task automatic reconfigure(int value);
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_node_count <= value[NCOUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_node_count(value[NCOUNT_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int phase_nodes;
    int eff;
    int len;
    int a;
    int b;
    int r;
    bit fresh;
    bit last;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_START;
    in_from_node = '0;
    in_to_node = '0;
    in_last_edge = 1'b0;
    cfg_valid = 1'b0;
    cfg_node_count = NODE_COUNT_RST;
    no_idle = 1'b0;
    choke_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. With the reset node count, the corner endpoints join,
    // a repeat of the same pair and a self loop are turned away, and a
    // last-edge mark on an unfinished tree raises ran_out while later edges
    // are still processed.
    push_start();
    push_edge(0, 1023, 0);
    push_edge(1023, 0, 0);
    push_edge(5, 5, 0);
    push_edge(1023, 512, 1);
    push_edge(0, 512, 0);
    feed_pending();

    // A node count of zero acts as two: an endpoint at two is out of range,
    // one edge completes the tree, and an edge after completion is rejected.
    reconfigure(0);
    push_start();
    push_edge(0, 2, 0);
    push_edge(1, 0, 1);
    push_edge(0, 1, 1);
    feed_pending();

    reconfigure(1);
    push_start();
    push_edge(1, 1, 0);
    push_edge(0, 1, 1);
    feed_pending();

    // The top of the register range acts as the memory size.
    reconfigure(2047);
    push_start();
    push_edge(1023, 1022, 0);
    push_edge(1022, 1, 1);
    feed_pending();

    reconfigure(4);
    push_start();
    push_edge(0, 1, 0);
    push_edge(2, 3, 0);
    push_edge(1, 2, 1);
    feed_pending();

    // Lowering the count under a forest that already holds enough edges for it
    // closes it; raising the count again does not reopen it until the next start.
    reconfigure(1024);
    push_start();
    push_edge(3, 0, 0);
    push_edge(1, 0, 0);
    feed_pending();
    reconfigure(3);
    push_edge(5, 6, 1);
    feed_pending();
    reconfigure(1025);
    push_edge(5, 6, 0);
    feed_pending();

    // Random part. Each phase picks a node count, mostly small so that trees
    // really complete, usually opens a fresh forest, and offers an edge list
    // whose length, for small counts, straddles what completion needs, with the
    // last-edge mark on its final entry unless that entry is noise. A few
    // endpoints fall out of range and a few transactions are plain noise.
    sent = 0;
    while (sent < 1800) begin
      r = $urandom_range(0, 99);
      if (r < 65) phase_nodes = $urandom_range(2, 24);
      else if (r < 80) phase_nodes = $urandom_range(25, 160);
      else if (r < 88) phase_nodes = 1024;
      else if (r < 93) phase_nodes = $urandom_range(1025, 2047);
      else if (r < 96) phase_nodes = $urandom_range(0, 1);
      else phase_nodes = $urandom_range(161, 1023);
      eff = phase_nodes < 2 ? 2 : (phase_nodes > MAX_NODES_DEF ? MAX_NODES_DEF : phase_nodes);

      reconfigure(phase_nodes);
      no_idle = ($urandom_range(0, 99) < 20);
      // Sometimes the old forest carries on under the new count.
      fresh = ($urandom_range(0, 99) < 88);
      if (fresh) push_start();

      if (eff <= 64) len = $urandom_range(eff / 2 + 1, 2 * eff);
      else len = $urandom_range(20, 70);

      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          push_edge($urandom_range(0, 1023), $urandom_range(0, 1023),
                    1'($urandom_range(0, 1)));
        end else begin
          a = $urandom_range(0, eff - 1);
          b = $urandom_range(0, eff - 1);
          if (r < 11 && eff < MAX_NODES_DEF) begin
            if ($urandom_range(0, 1)) a = $urandom_range(eff, 1023);
            else b = $urandom_range(eff, 1023);
          end
          last = (i == len - 1);
          push_edge(a, b, last);
        end
      end

      // Partway through, the receiver holds off for a long stretch while a
      // phase with enough transactions to fill the block is being offered.
      if (sent > 700 && !choke_req && pending.size() >= 4) choke_req = 1'b1;
      sent += pending.size();
      feed_pending();
    end

    // Let every outstanding result come back, then allow a short tail for
    // anything the block should not have produced.
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including the clearing pass
  // after reset and the one behind every start transaction.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ===== kruskal_union_find_edge_select.f =====
rtl/kuf_pkg.sv
rtl/kruskal_union_find_edge_select.sv
rtl/kuf_checker.sv
tb/sv/tb_kruskal_union_find_edge_select.sv
